// File: src/dsne_pkg.sv
package dsne_pkg;

    localparam int PIX_W     = 8;
    localparam int OUT_W     = 16;
    localparam int FRAC_BITS = 15;

    // Register indexes (byte address bits [3:2])
    localparam logic [1:0] REG_WIDTH  = 2'd0;
    localparam logic [1:0] REG_HEIGHT = 2'd1;
    localparam logic [1:0] REG_RADIUS = 2'd2;

    localparam logic [10:0] WIDTH_RESET  = 11'd640;
    localparam logic [15:0] HEIGHT_RESET = 16'd480;
    localparam logic [3:0]  RADIUS_RESET = 4'd3;

    typedef enum logic [1:0] {
        T_IDLE,
        T_READ,
        T_CALC,
        T_DONE
    } top_state_t;

    typedef enum logic [1:0] {
        N_IDLE,
        N_SQR,
        N_SUM,
        N_ROOT
    } norm_state_t;

    typedef struct packed {
        logic [PIX_W-1:0] za;
        logic [PIX_W-1:0] zb;
        logic [PIX_W-1:0] zc;
    } samples_t;

    typedef struct packed {
        logic signed [OUT_W-1:0] x;
        logic signed [OUT_W-1:0] y;
        logic signed [OUT_W-1:0] z;
    } norm_res_t;

endpackage

// File: src/dsne_line_store.sv
module dsne_line_store import dsne_pkg::*; #(
    parameter int AW    = 15,
    parameter int DEPTH = 17408
) (
    input  logic             aclk,
    input  logic             wr_en,
    input  logic [AW-1:0]    wr_addr,
    input  logic [PIX_W-1:0] wr_data,
    input  logic [AW-1:0]    rd_addr_a,
    input  logic [AW-1:0]    rd_addr_b,
    output logic [PIX_W-1:0] rd_data_a,
    output logic [PIX_W-1:0] rd_data_b
);

    logic [PIX_W-1:0] mem [DEPTH];

    // Write the incoming pixel
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
    end

    // Read two neighbors, registered
    always_ff @(posedge aclk) begin
        rd_data_a <= mem[rd_addr_a];
        rd_data_b <= mem[rd_addr_b];
    end

endmodule

// File: src/dsne_norm_unit.sv
module dsne_norm_unit import dsne_pkg::*; #(
    parameter int RW = 4
) (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          start,
    input  samples_t      smp,
    input  logic [RW-1:0] r,
    output logic          done,
    output norm_res_t     res
);

    localparam int NW  = 12 + RW;
    localparam int MW  = NW - 1;
    localparam int SQW = 2 * MW;
    localparam int SW  = SQW + 2;
    localparam int LW  = SQW + 2 * FRAC_BITS;
    localparam int QW  = SW + 2 * FRAC_BITS + 1;
    localparam int PW  = SW + FRAC_BITS;

    norm_state_t state_reg, state_next;
    logic [3:0]  bit_reg, bit_next;
    logic [1:0]  comp_reg, comp_next;
    logic        done_reg, done_next;

    logic [MW-1:0]  mag_reg [3];
    logic           neg_reg [3];
    logic [SQW-1:0] sq_reg  [3];
    logic [SW-1:0]  s_reg;
    logic [LW-1:0]  l_reg;
    logic [QW-1:0]  q_reg;
    logic [PW-1:0]  p_reg;
    logic [FRAC_BITS-1:0] y_reg;
    norm_res_t      res_reg;

    logic signed [10:0]   dx, dy;
    logic signed [NW-1:0] nx, ny;
    logic [MW-1:0]        nz;
    logic [QW-1:0]        q_try;
    logic                 fit;
    logic [FRAC_BITS-1:0] y_new;
    logic [OUT_W-1:0]     y_signed;

    // Raw normal components
    always_comb begin
        dx = $signed({2'b00, smp.zc, 1'b0}) - $signed({3'b000, smp.za})
             - $signed({3'b000, smp.zb});
        dy = $signed({3'b000, smp.za}) - $signed({3'b000, smp.zb});
        nx = NW'(dx) * NW'($signed({1'b0, r}));
        ny = NW'(dy) * NW'($signed({1'b0, r, 1'b0}));
        nz = (MW'(r) * MW'(r)) << 2;
    end

    // One result bit per cycle: test (y+b)^2*S against c^2*2^30
    always_comb begin
        q_try = q_reg + (QW'(p_reg) << (bit_reg + 4'd1)) + (QW'(s_reg) << {bit_reg, 1'b0});
        fit   = q_try <= QW'(l_reg);
        y_new = fit ? (y_reg | (FRAC_BITS'(1) << bit_reg)) : y_reg;
        y_signed = neg_reg[comp_reg] ? (OUT_W'(0) - OUT_W'(y_new)) : OUT_W'(y_new);
    end

    always_comb begin
        state_next = state_reg;
        bit_next   = bit_reg;
        comp_next  = comp_reg;
        done_next  = 1'b0;
        case (state_reg)
            N_IDLE: begin
                if (start) begin
                    state_next = N_SQR;
                end
            end
            N_SQR: begin
                state_next = N_SUM;
            end
            N_SUM: begin
                state_next = N_ROOT;
                comp_next  = 2'd0;
                bit_next   = 4'(FRAC_BITS - 1);
            end
            N_ROOT: begin
                if (bit_reg == 4'd0) begin
                    bit_next = 4'(FRAC_BITS - 1);
                    if (comp_reg == 2'd2) begin
                        state_next = N_IDLE;
                        done_next  = 1'b1;
                    end else begin
                        comp_next = comp_reg + 2'd1;
                    end
                end else begin
                    bit_next = bit_reg - 4'd1;
                end
            end
            default: state_next = N_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= N_IDLE;
            bit_reg   <= '0;
            comp_reg  <= '0;
            done_reg  <= 1'b0;
        end else begin
            state_reg <= state_next;
            bit_reg   <= bit_next;
            comp_reg  <= comp_next;
            done_reg  <= done_next;
        end
    end

    // Datapath registers
    always_ff @(posedge aclk) begin
        case (state_reg)
            N_IDLE: begin
                if (start) begin
                    mag_reg[0] <= nx[NW-1] ? MW'(-nx) : MW'(nx);
                    mag_reg[1] <= ny[NW-1] ? MW'(-ny) : MW'(ny);
                    mag_reg[2] <= nz;
                    neg_reg[0] <= nx[NW-1];
                    neg_reg[1] <= ny[NW-1];
                    neg_reg[2] <= 1'b0;
                end
            end
            N_SQR: begin
                for (int i = 0; i < 3; i++) begin
                    sq_reg[i] <= SQW'(mag_reg[i]) * SQW'(mag_reg[i]);
                end
            end
            N_SUM: begin
                s_reg <= SW'(sq_reg[0]) + SW'(sq_reg[1]) + SW'(sq_reg[2]);
                l_reg <= {sq_reg[0], (2 * FRAC_BITS)'(0)};
                q_reg <= '0;
                p_reg <= '0;
                y_reg <= '0;
            end
            N_ROOT: begin
                if (bit_reg == 4'd0) begin
                    case (comp_reg)
                        2'd0:    res_reg.x <= $signed(y_signed);
                        2'd1:    res_reg.y <= $signed(y_signed);
                        default: res_reg.z <= $signed(y_signed);
                    endcase
                    if (comp_reg != 2'd2) begin
                        l_reg <= {sq_reg[comp_reg + 2'd1], (2 * FRAC_BITS)'(0)};
                    end
                    q_reg <= '0;
                    p_reg <= '0;
                    y_reg <= '0;
                end else begin
                    y_reg <= y_new;
                    if (fit) begin
                        q_reg <= q_try;
                        p_reg <= p_reg + (PW'(s_reg) << bit_reg);
                    end
                end
            end
            default: ;
        endcase
    end

    assign done = done_reg;
    assign res  = res_reg;

endmodule

// File: src/depth_surface_normal_estimator.sv
// Sequencing: a pixel that yields no normal is done in its transfer cycle; for one that does,
//   the samples are read (T_READ), then an invalid normal goes straight to T_DONE, and a computed
//   one is squared, summed and root-searched in the norm unit, handed to T_DONE, then output.
// Throughput: one pixel per cycle outside the centre window; inside it no new pixel is taken
//   until the last one's normal is loaded for output, which can wait on an m_ready stall.
// Reset (aresetn low, synchronous): counters and handshakes clear, registers 640/480/3.
module depth_surface_normal_estimator import dsne_pkg::*; #(
    parameter int MAX_WIDTH  = 1024,
    parameter int MAX_RADIUS = 8
) (
    input  logic                    aclk,
    input  logic                    aresetn,
    input  logic                    psel,
    input  logic                    penable,
    input  logic                    pwrite,
    input  logic [3:0]              paddr,
    input  logic [31:0]             pwdata,
    output logic [31:0]             prdata,
    output logic                    pready,
    input  logic                    s_valid,
    output logic                    s_ready,
    input  logic [PIX_W-1:0]        s_depth_pixel,
    output logic                    m_valid,
    input  logic                    m_ready,
    output logic signed [OUT_W-1:0] m_normal_x,
    output logic signed [OUT_W-1:0] m_normal_y,
    output logic signed [OUT_W-1:0] m_normal_z,
    output logic                    m_invalid,
    output logic                    m_frame_last
);

    localparam int CW    = $clog2(MAX_WIDTH);
    localparam int RW    = $clog2(MAX_RADIUS + 1);
    localparam int ROWS  = 2 * MAX_RADIUS + 1;
    localparam int SLW   = $clog2(ROWS);
    localparam int AW    = SLW + CW;
    localparam int DEPTH = ROWS << CW;

    logic [10:0] width_reg;
    logic [15:0] height_reg;
    logic [3:0]  radius_reg;

    top_state_t     state_reg, state_next;
    logic [CW-1:0]  col_reg, col_next;
    logic [15:0]    row_reg, row_next;
    logic [SLW-1:0] slot_reg, slot_next;
    logic           m_valid_reg, m_valid_next;

    logic [PIX_W-1:0] zb_reg;
    logic [RW-1:0]    r_reg;
    logic             last_reg;
    logic             bad_reg;
    norm_res_t        res_reg;
    norm_res_t        out_reg;
    logic             out_bad_reg;
    logic             out_last_reg;

    logic             cfg_wr;
    logic             accept;
    logic [15:0]      w_eff;
    logic [RW-1:0]    r_eff;
    logic [RW:0]      two_r;
    logic             end_col, row_last, has_res;
    logic [CW-1:0]    za_col, zc_col;
    logic [SLW:0]     slot_ext, tr_ext;
    logic [SLW-1:0]   zc_slot;
    logic [PIX_W-1:0] rd_a, rd_b;
    logic             norm_start, norm_done, out_load;
    samples_t         smp;
    norm_res_t        norm_res;

    // Configuration port
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            width_reg  <= WIDTH_RESET;
            height_reg <= HEIGHT_RESET;
            radius_reg <= RADIUS_RESET;
        end else if (cfg_wr) begin
            case (paddr[3:2])
                REG_WIDTH:  width_reg  <= pwdata[10:0];
                REG_HEIGHT: height_reg <= pwdata[15:0];
                REG_RADIUS: radius_reg <= pwdata[3:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (paddr[3:2])
            REG_WIDTH:  prdata = 32'(width_reg);
            REG_HEIGHT: prdata = 32'(height_reg);
            REG_RADIUS: prdata = 32'(radius_reg);
            default:    prdata = '0;
        endcase
    end

    // Effective geometry and sample addressing
    always_comb begin
        w_eff = (16'(width_reg) > 16'(MAX_WIDTH)) ? 16'(MAX_WIDTH) : 16'(width_reg);
        r_eff = (5'(radius_reg) > 5'(MAX_RADIUS)) ? RW'(MAX_RADIUS) : RW'(radius_reg);
        two_r = {r_eff, 1'b0};
        end_col  = (16'(col_reg) + 16'd1) >= w_eff;
        row_last = (17'(row_reg) + 17'd1) >= 17'(height_reg);
        has_res  = (r_eff != '0) && (row_reg >= 16'(two_r))
                   && (16'(col_reg) >= 16'(two_r)) && (16'(col_reg) < w_eff);
        za_col   = col_reg - CW'(two_r);
        zc_col   = col_reg - CW'(r_eff);
        slot_ext = {1'b0, slot_reg};
        tr_ext   = (SLW + 1)'(two_r);
        zc_slot  = (slot_ext >= tr_ext) ? SLW'(slot_ext - tr_ext)
                                        : SLW'(slot_ext + (SLW + 1)'(ROWS) - tr_ext);
    end

    assign accept = s_valid && s_ready;
    assign s_ready = aresetn && (state_reg == T_IDLE);

    dsne_line_store #(
        .AW    (AW),
        .DEPTH (DEPTH)
    ) u_store (
        .aclk      (aclk),
        .wr_en     (accept),
        .wr_addr   ({slot_reg, col_reg}),
        .wr_data   (s_depth_pixel),
        .rd_addr_a ({slot_reg, za_col}),
        .rd_addr_b ({zc_slot, zc_col}),
        .rd_data_a (rd_a),
        .rd_data_b (rd_b)
    );

    assign smp = '{za: rd_a, zb: zb_reg, zc: rd_b};

    dsne_norm_unit #(
        .RW (RW)
    ) u_norm (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (norm_start),
        .smp     (smp),
        .r       (r_reg),
        .done    (norm_done),
        .res     (norm_res)
    );

    // Sequencer and raster counters
    always_comb begin
        state_next   = state_reg;
        col_next     = col_reg;
        row_next     = row_reg;
        slot_next    = slot_reg;
        norm_start   = 1'b0;
        out_load     = 1'b0;
        case (state_reg)
            T_IDLE: begin
                if (accept) begin
                    if (end_col) begin
                        col_next = '0;
                        if (row_last) begin
                            row_next  = '0;
                            slot_next = '0;
                        end else begin
                            row_next  = row_reg + 16'd1;
                            slot_next = (slot_reg == SLW'(ROWS - 1)) ? '0 : slot_reg + 1'b1;
                        end
                    end else begin
                        col_next = col_reg + 1'b1;
                    end
                    state_next = has_res ? T_READ : T_IDLE;
                end
            end
            T_READ: begin
                if (rd_a == '0 || zb_reg == '0 || rd_b == '0) begin
                    state_next = T_DONE;
                end else begin
                    norm_start = 1'b1;
                    state_next = T_CALC;
                end
            end
            T_CALC: begin
                if (norm_done) begin
                    state_next = T_DONE;
                end
            end
            T_DONE: begin
                if (!m_valid_reg || m_ready) begin
                    out_load   = 1'b1;
                    state_next = T_IDLE;
                end
            end
            default: state_next = T_IDLE;
        endcase
        m_valid_next = out_load ? 1'b1 : (m_ready ? 1'b0 : m_valid_reg);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= T_IDLE;
            col_reg     <= '0;
            row_reg     <= '0;
            slot_reg    <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            col_reg     <= col_next;
            row_reg     <= row_next;
            slot_reg    <= slot_next;
            m_valid_reg <= m_valid_next;
        end
    end

    // Hold item context and results
    always_ff @(posedge aclk) begin
        if (accept) begin
            zb_reg   <= s_depth_pixel;
            r_reg    <= r_eff;
            last_reg <= end_col && row_last;
        end
        if (state_reg == T_READ) begin
            bad_reg <= (rd_a == '0 || zb_reg == '0 || rd_b == '0);
            res_reg <= '0;
        end
        if (state_reg == T_CALC && norm_done) begin
            res_reg <= norm_res;
        end
        if (out_load) begin
            out_reg      <= res_reg;
            out_bad_reg  <= bad_reg;
            out_last_reg <= last_reg;
        end
    end

    assign m_valid      = m_valid_reg;
    assign m_normal_x   = out_reg.x;
    assign m_normal_y   = out_reg.y;
    assign m_normal_z   = out_reg.z;
    assign m_invalid    = out_bad_reg;
    assign m_frame_last = out_last_reg;

`ifndef ASSERT_OFF
    a_done_in_calc: assert property (@(posedge aclk) disable iff (!aresetn)
        norm_done |-> state_reg == T_CALC)
        else $error("norm unit finished outside calc state");

    a_calc_to_done: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == T_CALC && norm_done) |=> state_reg == T_DONE)
        else $error("finished normal not moved to output stage");

    a_invalid_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_invalid) |->
            (m_normal_x == '0 && m_normal_y == '0 && m_normal_z == '0))
        else $error("invalid normal carries nonzero components");

    a_z_positive: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_invalid) |-> (!m_normal_z[OUT_W-1] && m_normal_z != '0))
        else $error("depth component not positive");
`endif

endmodule

// File: dv/depth_surface_normal_estimator_test.sv
module depth_surface_normal_estimator_test;
    import dsne_pkg::*;

    localparam int STORE_ROWS = 17;
    localparam int STORE_COLS = 1024;
    localparam int STALL_LIMIT = 5000;
    localparam int DRAIN_CYCLES = 64;

    typedef struct {
        logic signed [OUT_W-1:0] x;
        logic signed [OUT_W-1:0] y;
        logic signed [OUT_W-1:0] z;
        logic                    bad;
        logic                    last;
    } normal_t;

    // Tracks the line store and counters, predicts each normal, checks results
    class normal_scoreboard;
        normal_t        pending[$];
        logic [7:0]     depth_rows[STORE_ROWS*STORE_COLS];
        int unsigned    col, row, width_reg, height_reg, radius_reg;
        int             errors;

        function new();
            col = 0;
            row = 0;
            width_reg = WIDTH_RESET;
            height_reg = HEIGHT_RESET;
            radius_reg = RADIUS_RESET;
            errors = 0;
        endfunction

        function void set_reg(logic [1:0] idx, int unsigned val);
            case (idx)
                REG_WIDTH: width_reg = val & 32'h7ff;
                REG_HEIGHT: height_reg = val & 32'hffff;
                REG_RADIUS: radius_reg = val & 32'hf;
                default: ;
            endcase
        endfunction

        // Largest q with q*q*s <= c*c*2^30, saturated to 32767, signed like c
        function logic signed [OUT_W-1:0] unit_part(longint c, longint unsigned s);
            longint unsigned mag, lim, lo, hi, mid;
            mag = (c < 0) ? -c : c;
            lim = (mag * mag) << 30;
            lo = 0;
            hi = 32767;
            while (lo < hi) begin
                mid = (lo + hi + 1) >> 1;
                if (mid * mid * s <= lim) lo = mid;
                else hi = mid - 1;
            end
            return (c < 0) ? -lo[OUT_W-1:0] : lo[OUT_W-1:0];
        endfunction

        function void note_pixel(logic [7:0] zb);
            int unsigned w, h, r, za, zc;
            logic end_col, end_frame;
            longint nx, ny, nz;
            longint unsigned s;
            normal_t n;
            w = (width_reg > STORE_COLS) ? STORE_COLS : width_reg;
            h = height_reg;
            r = (radius_reg > 8) ? 8 : radius_reg;
            end_col = (col + 1 >= w);
            end_frame = end_col && (row + 1 >= h);
            depth_rows[(row % STORE_ROWS) * STORE_COLS + (col % STORE_COLS)] = zb;
            if (r != 0 && row >= 2*r && col >= 2*r && col < w) begin
                za = depth_rows[(row % STORE_ROWS) * STORE_COLS + ((col - 2*r) % STORE_COLS)];
                zc = depth_rows[((row - 2*r) % STORE_ROWS) * STORE_COLS
                                + ((col - r) % STORE_COLS)];
                n.x = '0;
                n.y = '0;
                n.z = '0;
                n.bad = (za == 0 || zb == 0 || zc == 0);
                n.last = end_frame;
                if (!n.bad) begin
                    nx = longint'(r) * (2*longint'(zc) - longint'(za) - longint'(zb));
                    ny = -2 * longint'(r) * (longint'(zb) - longint'(za));
                    nz = 4 * longint'(r) * longint'(r);
                    s = nx*nx + ny*ny + nz*nz;
                    n.x = unit_part(nx, s);
                    n.y = unit_part(ny, s);
                    n.z = unit_part(nz, s);
                end
                pending.insert(pending.size(), n);
            end
            // Advance column, then row, wrapping at the frame edges
            if (end_col) begin
                col = 0;
                row = (row + 1 >= h) ? 0 : ((row + 1) & 32'hffff);
            end else begin
                col = (col + 1) & 32'h3ff;
            end
        endfunction

        function void check_normal(logic signed [OUT_W-1:0] x, logic signed [OUT_W-1:0] y,
                                   logic signed [OUT_W-1:0] z, logic bad, logic last);
            normal_t e;
            if (pending.size() == 0) begin
                $display("%0t: unexpected normal x=%0d y=%0d z=%0d invalid=%0b last=%0b",
                         $time, x, y, z, bad, last);
                errors++;
                return;
            end
            e = pending.pop_front();
            if (x !== e.x || y !== e.y || z !== e.z || bad !== e.bad || last !== e.last) begin
                $display("%0t: expected x=%0d y=%0d z=%0d invalid=%0b last=%0b", $time,
                         e.x, e.y, e.z, e.bad, e.last);
                $display("%0t: actual   x=%0d y=%0d z=%0d invalid=%0b last=%0b", $time,
                         x, y, z, bad, last);
                errors++;
            end
        endfunction
    endclass

    logic                    aclk;
    logic                    aresetn;
    logic                    psel, penable, pwrite;
    logic [3:0]              paddr;
    logic [31:0]             pwdata, prdata;
    logic                    pready;
    logic                    s_valid, s_ready;
    logic [PIX_W-1:0]        s_depth_pixel;
    logic                    m_valid, m_ready;
    logic signed [OUT_W-1:0] m_normal_x, m_normal_y, m_normal_z;
    logic                    m_invalid, m_frame_last;

    normal_scoreboard sb;
    bit               calm;
    int               quiet;
    int               random_items;

    depth_surface_normal_estimator u_top (
        .aclk(aclk), .aresetn(aresetn),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready),
        .s_valid(s_valid), .s_ready(s_ready), .s_depth_pixel(s_depth_pixel),
        .m_valid(m_valid), .m_ready(m_ready),
        .m_normal_x(m_normal_x), .m_normal_y(m_normal_y), .m_normal_z(m_normal_z),
        .m_invalid(m_invalid), .m_frame_last(m_frame_last)
    );

    initial begin
        aclk = 0;
        forever #5 aclk = ~aclk;
    end

    // Check every normal transfer
    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready)
            sb.check_normal(m_normal_x, m_normal_y, m_normal_z, m_invalid, m_frame_last);
    end

    // Watchdog on cycles with no transfer at all
    always @(posedge aclk) begin
        if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready) || psel) begin
            quiet <= 0;
        end else begin
            quiet <= quiet + 1;
            if (quiet >= STALL_LIMIT) begin
                $display("depth_surface_normal_estimator: mismatch");
                $finish;
            end
        end
    end

    // Result side backpressure in random bursts
    initial begin
        m_ready = 1'b0;
        @(posedge aclk iff aresetn);
        forever begin
            if (!calm && $urandom_range(0, 2) == 0) begin
                m_ready <= 1'b0;
                repeat ($urandom_range(1, 18)) @(posedge aclk);
            end
            m_ready <= 1'b1;
            repeat ($urandom_range(1, 30)) @(posedge aclk);
        end
    end

    task automatic reg_write(logic [1:0] idx, int unsigned val);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {idx, 2'b00};
        pwdata <= val;
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        sb.set_reg(idx, val);
        @(posedge aclk);
    endtask

    task automatic send_pixel(logic [7:0] p, bit allow_idle);
        if (allow_idle && !calm && $urandom_range(0, 9) == 0) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 18)) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_depth_pixel <= p;
        do @(posedge aclk); while (!s_ready);
        sb.note_pixel(p);
    endtask

    // Hold until every normal is back, then let the pipeline settle
    task automatic drain();
        s_valid <= 1'b0;
        while (sb.pending.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    task automatic set_geometry(int unsigned w, int unsigned h, int unsigned r);
        reg_write(REG_WIDTH, w);
        reg_write(REG_HEIGHT, h);
        reg_write(REG_RADIUS, r);
    endtask

    function automatic logic [7:0] random_depth();
        return ($urandom_range(0, 7) == 0) ? 8'd0 : 8'($urandom_range(1, 255));
    endfunction

    // Stream whole frames of random depth at the given geometry
    task automatic run_frames(int unsigned w, int unsigned h, int unsigned r, int frames,
                              bit allow_idle);
        int unsigned weff, heff;
        set_geometry(w, h, r);
        weff = (w == 0) ? 1 : ((w > STORE_COLS) ? STORE_COLS : w);
        heff = (h == 0) ? 1 : h;
        repeat (frames * weff * heff) send_pixel(random_depth(), allow_idle);
        drain();
    endtask

    initial begin
        logic [7:0] flat_frame[15];
        int unsigned w, h;
        sb = new();
        calm = 0;
        aresetn = 1'b0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        s_valid = 1'b0;
        s_depth_pixel = '0;
        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Flat, invalid and extreme-slope normals in one 5x3 frame
        flat_frame = '{8'd255, 8'd255, 8'd0,   8'd255, 8'd1,
                       8'd7,   8'd9,   8'd11,  8'd13,  8'd15,
                       8'd255, 8'd128, 8'd255, 8'd200, 8'd1};
        set_geometry(5, 3, 1);
        foreach (flat_frame[k]) send_pixel(flat_frame[k], 1'b1);
        drain();

        // Register extremes and special geometries
        run_frames(3, 3, 1, 2, 1'b1);
        run_frames(0, 5, 3, 1, 1'b0);
        run_frames(6, 0, 2, 3, 1'b1);
        run_frames(17, 17, 15, 1, 1'b1);
        run_frames(5, 4, 0, 2, 1'b1);
        run_frames(4, 9, 2, 1, 1'b1);

        // Random small frames; the last stretch runs without idling
        random_items = 0;
        while (random_items < 330) begin
            if (random_items > 240) calm = 1;
            w = $urandom_range(3, 12);
            h = $urandom_range(3, 10);
            run_frames(w, h, $urandom_range(1, 3), 1, 1'b1);
            random_items += w * h;
        end

        if (sb.errors == 0 && sb.pending.size() == 0) begin
            $display("depth_surface_normal_estimator: match");
        end else begin
            $display("depth_surface_normal_estimator: mismatch");
        end
        $finish;
    end
endmodule

// File: files.f
src/dsne_pkg.sv
src/dsne_line_store.sv
src/dsne_norm_unit.sv
src/depth_surface_normal_estimator.sv
dv/depth_surface_normal_estimator_test.sv
